// File: sv/ftfig_pkg.sv
`timescale 1ns / 1ps
// ftfig_pkg: shared constants, types and width helpers for the track format
// image generator. No dependencies.
package ftfig_pkg;

  // Image byte values
  localparam logic [7:0] BYTE_GAP  = 8'h4E;
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_SYNC = 8'hF5;
  localparam logic [7:0] BYTE_IDAM = 8'hFE;
  localparam logic [7:0] BYTE_DAM  = 8'hFB;
  localparam logic [7:0] BYTE_CRC  = 8'hF7;

  // Layout
  localparam int GAP1_LEN     = 60;
  localparam int REC_OVERHEAD = 100;  // record bytes besides the sector data
  localparam int DATA_START   = 59;   // offset of first data byte in a record

  // Record field offsets
  localparam int OFS_SYNC1 = 12;
  localparam int OFS_IDAM  = 15;
  localparam int OFS_TRACK = 16;
  localparam int OFS_SIDE  = 17;
  localparam int OFS_SECT  = 18;
  localparam int OFS_SIZE  = 19;
  localparam int OFS_IDCRC = 20;
  localparam int OFS_GAP2  = 21;
  localparam int OFS_ZERO2 = 43;
  localparam int OFS_SYNC2 = 55;
  localparam int OFS_DAM   = 58;

  // Register indexes
  typedef enum logic [1:0] {
    REG_SPT   = 2'd0,
    REG_TRACK = 2'd1,
    REG_SIDE  = 2'd2,
    REG_FILL  = 2'd3
  } cfg_reg_t;

  // Region flags handed from the counter to the byte decoder
  typedef struct packed {
    logic gap1;    // position lies in GAP1
    logic record;  // position lies inside a sector record
  } region_t;

  // Size code: halvings of the sector size down to 128, at most 7
  function automatic int size_code(input int sb);
    int c;
    int s;
    c = 0;
    s = sb;
    for (int i = 0; i < 7; i++) begin
      if (s > 128) begin
        s = s >> 1;
        c = c + 1;
      end
    end
    return c;
  endfunction

  function automatic int pos_width(input int tb, input int sb, input int ms);
    return $clog2(tb + (sb + REC_OVERHEAD) * ms + 64);
  endfunction

  function automatic int off_width(input int sb);
    return $clog2(sb + REC_OVERHEAD);
  endfunction

  function automatic int rec_width(input int tb, input int ms);
    return $clog2(tb / 128 + ms + 2);
  endfunction

endpackage

// File: sv/ftfig_byte_dec.sv
`timescale 1ns / 1ps
// ftfig_byte_dec: decodes the image byte from region, record offset and record
// number. Depends on ftfig_pkg.
module ftfig_byte_dec #(
  parameter int SECTOR_BYTES = 512,
  parameter int TRACK_BYTES  = 6250,
  parameter int MAX_SECTORS  = 10
) (
  input  ftfig_pkg::region_t                                   region,
  input  logic [ftfig_pkg::off_width(SECTOR_BYTES)-1:0]        offset,
  input  logic [ftfig_pkg::rec_width(TRACK_BYTES, MAX_SECTORS)-1:0] rec,
  input  logic [7:0]                                           track_number,
  input  logic                                                 side_number,
  input  logic [15:0]                                          fill_word,
  output logic [7:0]                                           data_byte
);
  import ftfig_pkg::*;

  localparam int OFF_W    = off_width(SECTOR_BYTES);
  localparam int DATA_END = DATA_START + SECTOR_BYTES;  // CRC byte of the data field
  localparam logic [7:0] SIZE_CODE = 8'(size_code(SECTOR_BYTES));

  always_comb begin
    data_byte = BYTE_GAP;
    if (region.record) begin
      if (offset < OFF_W'(OFS_SYNC1))       data_byte = BYTE_ZERO;
      else if (offset < OFF_W'(OFS_IDAM))   data_byte = BYTE_SYNC;
      else if (offset == OFF_W'(OFS_IDAM))  data_byte = BYTE_IDAM;
      else if (offset == OFF_W'(OFS_TRACK)) data_byte = track_number;
      else if (offset == OFF_W'(OFS_SIDE))  data_byte = {7'd0, side_number};
      else if (offset == OFF_W'(OFS_SECT))  data_byte = 8'(rec) + 8'd1;
      else if (offset == OFF_W'(OFS_SIZE))  data_byte = SIZE_CODE;
      else if (offset == OFF_W'(OFS_IDCRC)) data_byte = BYTE_CRC;
      else if (offset < OFF_W'(OFS_ZERO2))  data_byte = BYTE_GAP;
      else if (offset < OFF_W'(OFS_SYNC2))  data_byte = BYTE_ZERO;
      else if (offset < OFF_W'(OFS_DAM))    data_byte = BYTE_SYNC;
      else if (offset == OFF_W'(OFS_DAM))   data_byte = BYTE_DAM;
      else if (offset < OFF_W'(DATA_END)) begin
        // data starts at an odd offset: odd offsets carry the high fill byte
        data_byte = offset[0] ? fill_word[15:8] : fill_word[7:0];
      end
      else if (offset == OFF_W'(DATA_END))  data_byte = BYTE_CRC;
      else                                  data_byte = BYTE_GAP;
    end
  end

endmodule

// File: sv/ftfig_track_ctr.sv
`timescale 1ns / 1ps
// ftfig_track_ctr: image position counter with running GAP1/record split,
// image length, wrap and last-byte detection. Depends on ftfig_pkg.
module ftfig_track_ctr #(
  parameter int SECTOR_BYTES = 512,
  parameter int TRACK_BYTES  = 6250,
  parameter int MAX_SECTORS  = 10
) (
  input  logic                                                      clk,
  input  logic                                                      rst,
  input  logic                                                      advance,
  input  logic                                                      restart,
  input  logic [3:0]                                                spt,
  output logic                                                      err,
  output logic                                                      last,
  output logic [ftfig_pkg::pos_width(TRACK_BYTES, SECTOR_BYTES, MAX_SECTORS)-1:0] pos_eff,
  output ftfig_pkg::region_t                                        region,
  output logic [ftfig_pkg::off_width(SECTOR_BYTES)-1:0]             off_eff,
  output logic [ftfig_pkg::rec_width(TRACK_BYTES, MAX_SECTORS)-1:0] rec_eff
);
  import ftfig_pkg::*;

  localparam int POS_W   = pos_width(TRACK_BYTES, SECTOR_BYTES, MAX_SECTORS);
  localparam int OFF_W   = off_width(SECTOR_BYTES);
  localparam int REC_W   = rec_width(TRACK_BYTES, MAX_SECTORS);
  localparam int REC_LEN = SECTOR_BYTES + REC_OVERHEAD;

  // position and its split: GAP1 offset, or record number and record offset
  logic [POS_W-1:0] pos, pos_next;
  logic             gap1, gap1_next;
  logic [OFF_W-1:0] off, off_next;
  logic [REC_W-1:0] rec, rec_next;

  logic [POS_W-1:0] spt_w;
  logic [POS_W-1:0] used;
  logic [POS_W-1:0] len;
  logic             wrap;
  logic             gap1_eff;

  assign err   = (spt == 4'd0) || (spt > 4'(MAX_SECTORS));
  assign spt_w = POS_W'(spt);
  // GAP1 plus the records and their CRC bytes on disk
  assign used  = POS_W'(GAP1_LEN) + POS_W'(REC_LEN + 2) * spt_w;
  assign len   = (used <= POS_W'(TRACK_BYTES)) ? (POS_W'(TRACK_BYTES) - (spt_w << 1))
                                               : (POS_W'(GAP1_LEN) + POS_W'(REC_LEN) * spt_w);

  assign wrap     = restart || (pos >= len);
  assign pos_eff  = wrap ? '0 : pos;
  assign gap1_eff = wrap ? 1'b1 : gap1;
  assign off_eff  = wrap ? '0 : off;
  assign rec_eff  = wrap ? '0 : rec;
  assign last     = (pos_eff + POS_W'(1)) == len;

  assign region.gap1   = gap1_eff;
  assign region.record = !gap1_eff &&
                         ({{REC_W{1'b0}}, spt} > {4'd0, rec_eff});

  always_comb begin
    pos_next  = pos_eff + POS_W'(1);
    gap1_next = gap1_eff;
    off_next  = off_eff + OFF_W'(1);
    rec_next  = rec_eff;
    if (err || last) begin
      pos_next  = '0;
      gap1_next = 1'b1;
      off_next  = '0;
      rec_next  = '0;
    end else if (gap1_eff) begin
      if (off_eff == OFF_W'(GAP1_LEN - 1)) begin
        gap1_next = 1'b0;
        off_next  = '0;
      end
    end else if (off_eff == OFF_W'(REC_LEN - 1)) begin
      off_next = '0;
      rec_next = rec_eff + REC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      gap1 <= 1'b1;
      off  <= '0;
      rec  <= '0;
    end else if (advance) begin
      pos  <= pos_next;
      gap1 <= gap1_next;
      off  <= off_next;
      rec  <= rec_next;
    end
  end

  a_pos_in_image: assert property (@(posedge clk) disable iff (rst)
    !err |-> pos_eff < len)
    else $error("effective position beyond image length");

  a_step_one: assert property (@(posedge clk) disable iff (rst)
    advance && !err && !last |=> pos == $past(pos_eff) + POS_W'(1))
    else $error("position did not step by one");

  a_wrap_zero: assert property (@(posedge clk) disable iff (rst)
    advance && (err || last) |=> pos == '0 && gap1)
    else $error("position not back at zero after last byte or error");

  a_gap1_split: assert property (@(posedge clk) disable iff (rst)
    gap1 |-> pos == POS_W'(off))
    else $error("GAP1 offset out of step with position");

endmodule

// File: sv/floppy_track_format_image_generator_top.sv
`timescale 1ns / 1ps
// floppy_track_format_image_generator_top: write-track image byte generator,
// register file, stream handshake and result register. Depends on ftfig_pkg,
// ftfig_track_ctr and ftfig_byte_dec.
//
//  Channel  Dir  Handshake             Payload
//  s_*      in   s_tvalid / s_tready   s_tdata[0] restart
//  m_*      out  m_tvalid / m_tready   m_tdata data_byte, byte_index; m_tlast; m_tuser error
//  cfg_*    in   cfg_we                cfg_addr register index, cfg_wdata value
//
// One beat in, one beat out; a new beat is taken every cycle while the result
// register is empty or being drained (throughput 1 beat/cycle); the result is registered.
// The position counter and the byte decode sit between the counter state and
// the result register; the image length is a small constant multiply of spt.
// Reset (rst, synchronous) sets registers to their defaults (spt 9) and the
// position to byte zero. A stall on m_tready holds the result and drops s_tready.
module floppy_track_format_image_generator_top #(
  parameter int SECTOR_BYTES = 512,
  parameter int TRACK_BYTES  = 6250,
  parameter int MAX_SECTORS  = 10
) (
  input  logic        clk,
  input  logic        rst,
  // inbound stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
  // outbound stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] data_byte, [20:8] byte_index, [23:21] zero
  output logic        m_tlast,   // last byte of the image
  output logic        m_tuser,   // [0] error
  // register writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import ftfig_pkg::*;

  localparam int POS_W = pos_width(TRACK_BYTES, SECTOR_BYTES, MAX_SECTORS);
  localparam int OFF_W = off_width(SECTOR_BYTES);
  localparam int REC_W = rec_width(TRACK_BYTES, MAX_SECTORS);

  // configuration registers
  logic [3:0]  sectors_per_track;
  logic [7:0]  track_number;
  logic        side_number;
  logic [15:0] fill_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      sectors_per_track <= 4'd9;
      track_number      <= 8'd0;
      side_number       <= 1'b0;
      fill_word         <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_SPT:   sectors_per_track <= cfg_wdata[3:0];
        REG_TRACK: track_number      <= cfg_wdata[7:0];
        REG_SIDE:  side_number       <= cfg_wdata[0];
        REG_FILL:  fill_word         <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  // handshake: take a beat whenever the result register is free next cycle
  logic accept;
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  logic             err;
  logic             last;
  logic [POS_W-1:0] pos_eff;
  region_t          region;
  logic [OFF_W-1:0] off_eff;
  logic [REC_W-1:0] rec_eff;
  logic [7:0]       byte_val;

  ftfig_track_ctr #(
    .SECTOR_BYTES (SECTOR_BYTES),
    .TRACK_BYTES  (TRACK_BYTES),
    .MAX_SECTORS  (MAX_SECTORS)
  ) u_ctr (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .restart (s_tdata[0]),
    .spt     (sectors_per_track),
    .err     (err),
    .last    (last),
    .pos_eff (pos_eff),
    .region  (region),
    .off_eff (off_eff),
    .rec_eff (rec_eff)
  );

  ftfig_byte_dec #(
    .SECTOR_BYTES (SECTOR_BYTES),
    .TRACK_BYTES  (TRACK_BYTES),
    .MAX_SECTORS  (MAX_SECTORS)
  ) u_dec (
    .region       (region),
    .offset       (off_eff),
    .rec          (rec_eff),
    .track_number (track_number),
    .side_number  (side_number),
    .fill_word    (fill_word),
    .data_byte    (byte_val)
  );

  // result register; an error beat carries zero byte and index
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata[7:0]   <= err ? 8'd0 : byte_val;
      m_tdata[20:8]  <= err ? 13'd0 : pos_eff[12:0];
      m_tdata[23:21] <= 3'd0;
      m_tlast        <= !err && last;
      m_tuser        <= err;
    end
  end

  a_err_beat_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 24'd0 && !m_tlast)
    else $error("error beat carries data");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("beat taken while result register full");

endmodule

// File: bench/floppy_track_format_image_generator_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for floppy_track_format_image_generator_top. Depends on
// ftfig_pkg (byte values, layout offsets, register indexes) and the top level.
module floppy_track_format_image_generator_top_tb;
  import ftfig_pkg::*;

  localparam int SECTOR_BYTES = 512;
  localparam int TRACK_BYTES  = 6250;
  localparam int MAX_SECTORS  = 10;

  // record length as emitted, and as it lands on disk (each F7 grows to two CRC bytes)
  localparam int REC_LEN      = SECTOR_BYTES + REC_OVERHEAD;
  localparam int REC_DISK_LEN = SECTOR_BYTES + REC_OVERHEAD + 2;
  localparam int SIZE_CODE    = $clog2(SECTOR_BYTES / 128);

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 4;       // drain margin past the registered result
  localparam int RAND_PHASES  = 8;
  localparam int RAND_BEATS   = 25;      // per random phase
  localparam int WALK_BEATS   = 700;     // past the first record boundary
  localparam int MAX_REPORTS  = 40;

  // expected output beat
  typedef struct {
    logic [7:0]  data_byte;
    logic [12:0] byte_index;
    logic        last;
    logic        error;
  } image_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;    // [0] restart
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // [7:0] data_byte, [20:8] byte_index
  logic        m_tlast;
  logic        m_tuser;         // [0] error
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  // bench-side copy of the register file and generator position
  logic [3:0]  spt_reg   = 4'd9;
  logic [7:0]  track_reg = 8'd0;
  logic        side_reg  = 1'b0;
  logic [15:0] fill_reg  = 16'd0;
  int          next_pos  = 0;

  bit          restart_q[$];       // restart flags waiting to be sent
  image_beat_t byte_expect_q[$];   // predicted image bytes, oldest first

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  floppy_track_format_image_generator_top #(
    .SECTOR_BYTES(SECTOR_BYTES),
    .TRACK_BYTES (TRACK_BYTES),
    .MAX_SECTORS (MAX_SECTORS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Image model
  // ---------------------------------------------------------------------------

  // Bytes emitted for one image: GAP1, the records, then GAP5 padding the disk
  // image out to the track length (empty if the records already overrun it).
  function automatic int image_length(int spt);
    int used;
    used = GAP1_LEN + REC_DISK_LEN * spt;
    return GAP1_LEN + REC_LEN * spt + ((TRACK_BYTES > used) ? TRACK_BYTES - used : 0);
  endfunction

  // Byte at offset ofs of record sec (zero based)
  function automatic logic [7:0] record_byte(int ofs, int sec);
    if (ofs < OFS_SYNC1) return BYTE_ZERO;
    if (ofs < OFS_IDAM)  return BYTE_SYNC;
    if (ofs == OFS_IDAM)  return BYTE_IDAM;
    if (ofs == OFS_TRACK) return track_reg;
    if (ofs == OFS_SIDE)  return {7'd0, side_reg};
    if (ofs == OFS_SECT)  return 8'(sec + 1);
    if (ofs == OFS_SIZE)  return 8'(SIZE_CODE);
    if (ofs == OFS_IDCRC) return BYTE_CRC;
    if (ofs < OFS_ZERO2) return BYTE_GAP;
    if (ofs < OFS_SYNC2) return BYTE_ZERO;
    if (ofs < OFS_DAM)   return BYTE_SYNC;
    if (ofs == OFS_DAM)  return BYTE_DAM;
    // sector data: high fill byte on even data offsets, low on odd
    if (ofs < DATA_START + SECTOR_BYTES)
      return ((ofs - DATA_START) % 2 == 0) ? fill_reg[15:8] : fill_reg[7:0];
    if (ofs == DATA_START + SECTOR_BYTES) return BYTE_CRC;
    return BYTE_GAP;
  endfunction

  // Works out the byte for one accepted request and queues it
  task automatic predict_image_byte(input logic restart);
    image_beat_t exp_beat;
    int len;
    int rel;
    if (restart) next_pos = 0;
    if (spt_reg < 1 || spt_reg > MAX_SECTORS) begin
      // bad sector count: error beat, position back to zero
      next_pos = 0;
      exp_beat = '{data_byte: 8'd0, byte_index: 13'd0, last: 1'b0, error: 1'b1};
    end else begin
      len = image_length(spt_reg);
      // registers changed under a position past the new image end
      if (next_pos >= len) next_pos = 0;
      rel = next_pos - GAP1_LEN;
      if (next_pos < GAP1_LEN || rel >= REC_LEN * spt_reg)
        exp_beat.data_byte = BYTE_GAP;
      else
        exp_beat.data_byte = record_byte(rel % REC_LEN, rel / REC_LEN);
      exp_beat.byte_index = 13'(next_pos);
      exp_beat.last       = (next_pos + 1 == len);
      exp_beat.error      = 1'b0;
      next_pos = exp_beat.last ? 0 : next_pos + 1;
    end
    byte_expect_q.push_back(exp_beat);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: one restart flag per beat, random gaps between beats
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) predict_image_byte(s_tdata[0]);
      if (!s_tvalid || s_tready) begin
        if (restart_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {7'd0, restart_q.pop_front()};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: random back-pressure, field-by-field compare
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    image_beat_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (byte_expect_q.size() == 0) begin
          report_mismatch("unexpected beat, byte_index", m_tdata[20:8], -1);
        end else begin
          want = byte_expect_q.pop_front();
          if (m_tdata[7:0] !== want.data_byte)
            report_mismatch("data_byte", m_tdata[7:0], want.data_byte);
          if (m_tdata[20:8] !== want.byte_index)
            report_mismatch("byte_index", m_tdata[20:8], want.byte_index);
          if (m_tlast !== want.last)
            report_mismatch("last", m_tlast, want.last);
          if (m_tuser !== want.error)
            report_mismatch("error", m_tuser, want.error);
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequencing
  // ---------------------------------------------------------------------------

  // Blocks until every queued beat is sent and every byte has come back
  task automatic wait_idle();
    do @(negedge clk);
    while (restart_q.size() != 0 || s_tvalid || byte_expect_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_SPT:   spt_reg   = val[3:0];
      REG_TRACK: track_reg = val[7:0];
      REG_SIDE:  side_reg  = val[0];
      REG_FILL:  fill_reg  = val;
      default: ;
    endcase
  endtask

  // Drains the block, loads a full register set and picks the idle pattern
  task automatic start_phase(input logic [3:0] spt, input logic [7:0] trk,
                             input logic side, input logic [15:0] fill,
                             input int send_pct, input int stall_pct);
    wait_idle();
    write_reg(REG_SPT, {12'd0, spt});
    write_reg(REG_TRACK, {8'd0, trk});
    write_reg(REG_SIDE, {15'd0, side});
    write_reg(REG_FILL, fill);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // One restart, then n plain next-byte requests
  task automatic queue_image_walk(input int n);
    restart_q.push_back(1'b1);
    repeat (n) restart_q.push_back(1'b0);
  endtask

  initial begin
    logic [3:0] spt;
    int         mode;
    int         send_pct;
    int         stall_pct;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset registers (9 sectors), restart at start and mid-stream
    restart_q.push_back(1'b1);
    restart_q.push_back(1'b0);
    restart_q.push_back(1'b0);
    restart_q.push_back(1'b0);
    restart_q.push_back(1'b1);
    restart_q.push_back(1'b0);

    // Bad sector counts: zero, the top of the field, one past the maximum
    start_phase(4'd0, 8'd0, 1'b0, 16'h0000, 0, 0);
    restart_q.push_back(1'b0);
    restart_q.push_back(1'b1);
    start_phase(4'd15, 8'd255, 1'b1, 16'hFFFF, 82, 82);
    restart_q.push_back(1'b0);
    restart_q.push_back(1'b0);
    start_phase(4'(MAX_SECTORS + 1), 8'd255, 1'b1, 16'hFFFF, 0, 0);
    restart_q.push_back(1'b1);

    // Lowest good count right after an error: image picks up at byte zero
    start_phase(4'd1, 8'd255, 1'b1, 16'hFFFF, 0, 0);
    restart_q.push_back(1'b0);
    restart_q.push_back(1'b0);
    restart_q.push_back(1'b1);

    // Maximum count: GAP1, the whole first record and into the second one;
    // 00FF fill makes the high/low alternation visible
    start_phase(4'(MAX_SECTORS), 8'd255, 1'b1, 16'h00FF, 0, 0);
    queue_image_walk(WALK_BEATS);

    // One sector: the record, then on into the long GAP5
    start_phase(4'd1, 8'd0, 1'b0, 16'hFF00, 15, 15);
    queue_image_walk(WALK_BEATS);

    // Random phases. The first one raises the count under the parked GAP5
    // position, so the walk carries on inside the second record.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0)
        spt = 4'(MAX_SECTORS);
      else if ($urandom_range(7) == 0)
        spt = ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom_range(MAX_SECTORS + 1, 15));
      else
        spt = 4'($urandom_range(1, MAX_SECTORS));
      mode = ph % 4;
      send_pct  = (mode == 1) ? 82 : (mode == 3) ? 15 : 0;
      stall_pct = (mode == 2) ? 82 : (mode == 3) ? 15 : 0;
      start_phase(spt, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  16'($urandom_range(65535)), send_pct, stall_pct);
      // mostly a running walk through the image, with the odd restart
      repeat (RAND_BEATS) restart_q.push_back($urandom_range(299) == 0);
    end

    wait_idle();
    if (mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// File: filelist.f
sv/ftfig_pkg.sv
sv/ftfig_byte_dec.sv
sv/ftfig_track_ctr.sv
sv/floppy_track_format_image_generator_top.sv
bench/floppy_track_format_image_generator_top_tb.sv
